>>> rtl/sbh_pkg.sv
// ============================================================================
// SHA-256 byte stream hasher package
// Shared types, constants and round functions of the SHA-256 hasher.
// ============================================================================
`default_nettype none

package sbh_pkg;

    // Operation codes of an input beat.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Padding and sequencing constants.
    localparam logic [7:0]  PAD_MARK      = 8'h80;
    localparam logic [7:0]  PAD_ZERO      = 8'h00;
    localparam logic [5:0]  LEN_FILL      = 6'd56;
    localparam logic [5:0]  BLOCK_LAST    = 6'd63;
    localparam logic [5:0]  ROUND_LAST    = 6'd63;
    localparam logic [2:0]  WORD_LAST     = 3'd7;
    localparam logic [63:0] BLOCK_BITS    = 64'd512;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // What follows a compression.
    typedef enum logic [1:0] {
        CONT_IDLE,
        CONT_PAD,
        CONT_OUT
    } cont_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic       byte_shift;
        logic [7:0] byte_val;
        logic       round_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       final_add;
        logic       out_shift;
        logic [2:0] out_idx;
    } ctrl_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

>>> rtl/sha256_byte_stream_hasher_unit.sv
// ============================================================================
// SHA-256 byte stream hasher
// Hashes a byte stream and returns the eight digest words on finish.
// ============================================================================
// Usage: the input channel (in_valid/in_ready) carries one beat per item. An
// absorb beat (op = 0) brings one message byte in data_byte; a finish beat
// (op = 1) closes the message. The output channel (out_valid/out_ready)
// returns eight beats per finish: digest_word for word_index 0 to 7, with
// last high on word 7. The first digest byte is the top byte of word 0.
// Throughput: the block takes one absorb beat per cycle while it is idle;
// every 64th byte starts a compression (64 rounds of the shared round unit
// plus the chaining addition), during which in_ready is low.
// After a finish beat the padding bytes go into the block one per cycle,
// then the compression; a second block is needed when 56 or more bytes
// are pending.
// Reset clears the byte count and length and loads the initial hash values.
// in_ready is low while a block is compressed or the digest is out; when the
// receiver stalls, the current digest beat holds until it is taken, and the
// block takes the next message once the eighth beat has gone.
// ============================================================================
`default_nettype none

module sha256_byte_stream_hasher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last
);

    sbh_pkg::ctrl_t ctrl;
    logic [31:0]    w0;

    sbh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .word_index (word_index),
        .last       (last),
        .ctrl       (ctrl)
    );

    sbh_sched u_sched (
        .clk  (clk),
        .ctrl (ctrl),
        .w0   (w0)
    );

    sbh_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .w0          (w0),
        .digest_word (digest_word)
    );

`ifndef SYNTHESIS
    // The block never takes input while it presents a digest word.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while digest is presented");

    // A finish beat starts padding; nothing is offered or taken next cycle.
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && op == sbh_pkg::OP_FINISH) |=> (!in_ready && !out_valid))
        else $error("finish did not start padding");

    // After the last digest beat the block is ready for a new message.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (in_ready && !out_valid))
        else $error("block not idle after last digest word");
`endif

endmodule

`default_nettype wire

>>> rtl/sbh_ctrl.sv
// ============================================================================
// SHA-256 hasher sequencer
// Tracks fill and length, walks padding, rounds and digest output.
// ============================================================================
`default_nettype none

module sbh_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          op,
    input  wire logic [7:0]    data_byte,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         word_index,
    output logic               last,
    output sbh_pkg::ctrl_t     ctrl
);

    sbh_pkg::state_t state_reg, state_next;
    sbh_pkg::cont_t  cont_reg, cont_next;
    logic [5:0]      fill_reg, fill_next;
    logic [63:0]     bits_reg, bits_next;
    logic [63:0]     total_reg, total_next;
    logic [5:0]      rnd_reg, rnd_next;
    logic [2:0]      idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbh_pkg::ST_IDLE;
            cont_reg  <= sbh_pkg::CONT_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            total_reg <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cont_reg  <= cont_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            total_reg <= total_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cont_next       = cont_reg;
        fill_next       = fill_reg;
        bits_next       = bits_reg;
        total_next      = total_reg;
        rnd_next        = rnd_reg;
        idx_next        = idx_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        ctrl            = '0;
        ctrl.round_idx  = rnd_reg;
        ctrl.out_idx    = idx_reg;
        case (state_reg)
            sbh_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == sbh_pkg::OP_ABSORB)
                    begin
                        ctrl.byte_shift = 1'b1;
                        ctrl.byte_val   = data_byte;
                        fill_next       = fill_reg + 6'd1;
                        if (fill_reg == sbh_pkg::BLOCK_LAST)
                        begin
                            ctrl.round_load = 1'b1;
                            bits_next       = bits_reg + sbh_pkg::BLOCK_BITS;
                            cont_next       = sbh_pkg::CONT_IDLE;
                            rnd_next        = '0;
                            state_next      = sbh_pkg::ST_ROUND;
                        end
                    end
                    else
                    begin
                        total_next = bits_reg + {55'd0, fill_reg, 3'b000};
                        state_next = sbh_pkg::ST_MARK;
                    end
                end
            end
            sbh_pkg::ST_MARK:
            begin
                ctrl.byte_shift = 1'b1;
                ctrl.byte_val   = sbh_pkg::PAD_MARK;
                fill_next       = fill_reg + 6'd1;
                if (fill_reg == sbh_pkg::BLOCK_LAST)
                begin
                    ctrl.round_load = 1'b1;
                    cont_next       = sbh_pkg::CONT_PAD;
                    rnd_next        = '0;
                    state_next      = sbh_pkg::ST_ROUND;
                end
                else
                begin
                    state_next = sbh_pkg::ST_ZERO;
                end
            end
            sbh_pkg::ST_ZERO:
            begin
                if (fill_reg == sbh_pkg::LEN_FILL)
                begin
                    state_next = sbh_pkg::ST_LEN;
                end
                else
                begin
                    ctrl.byte_shift = 1'b1;
                    ctrl.byte_val   = sbh_pkg::PAD_ZERO;
                    fill_next       = fill_reg + 6'd1;
                    if (fill_reg == sbh_pkg::BLOCK_LAST)
                    begin
                        ctrl.round_load = 1'b1;
                        cont_next       = sbh_pkg::CONT_PAD;
                        rnd_next        = '0;
                        state_next      = sbh_pkg::ST_ROUND;
                    end
                end
            end
            sbh_pkg::ST_LEN:
            begin
                // Length goes out most significant byte first.
                ctrl.byte_shift = 1'b1;
                ctrl.byte_val   = total_reg[63:56];
                total_next      = {total_reg[55:0], 8'h00};
                fill_next       = fill_reg + 6'd1;
                if (fill_reg == sbh_pkg::BLOCK_LAST)
                begin
                    ctrl.round_load = 1'b1;
                    cont_next       = sbh_pkg::CONT_OUT;
                    rnd_next        = '0;
                    state_next      = sbh_pkg::ST_ROUND;
                end
            end
            sbh_pkg::ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == sbh_pkg::ROUND_LAST)
                begin
                    state_next = sbh_pkg::ST_FINAL;
                end
            end
            sbh_pkg::ST_FINAL:
            begin
                ctrl.final_add = 1'b1;
                case (cont_reg)
                    sbh_pkg::CONT_PAD:
                    begin
                        state_next = sbh_pkg::ST_ZERO;
                    end
                    sbh_pkg::CONT_OUT:
                    begin
                        idx_next   = '0;
                        state_next = sbh_pkg::ST_OUT;
                    end
                    default:
                    begin
                        state_next = sbh_pkg::ST_IDLE;
                    end
                endcase
            end
            sbh_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.out_shift = 1'b1;
                    idx_next       = idx_reg + 3'd1;
                    if (idx_reg == sbh_pkg::WORD_LAST)
                    begin
                        bits_next  = '0;
                        state_next = sbh_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sbh_pkg::ST_IDLE;
            end
        endcase
    end

    assign word_index = idx_reg;
    assign last       = (idx_reg == sbh_pkg::WORD_LAST);

endmodule

`default_nettype wire

>>> rtl/sbh_sched.sv
// ============================================================================
// SHA-256 block window and message schedule
// Sixteen-word window that takes message bytes and expands the schedule.
// ============================================================================
`default_nettype none

module sbh_sched (
    input  wire logic           clk,
    input  wire sbh_pkg::ctrl_t ctrl,
    output logic [31:0]         w0
);

    // Word i of the window sits at bits [511-32*i -: 32]; word 0 is the oldest.
    logic [511:0] win_reg, win_next;
    logic [31:0]  w_new;

    assign w_new = sbh_pkg::ssig1(win_reg[511-32*14 -: 32]) + win_reg[511-32*9 -: 32]
                 + sbh_pkg::ssig0(win_reg[511-32*1 -: 32]) + win_reg[511 -: 32];

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.byte_shift)
        begin
            win_next = {win_reg[503:0], ctrl.byte_val};
        end
        else if (ctrl.round_en)
        begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    assign w0 = win_reg[511 -: 32];

endmodule

`default_nettype wire

>>> rtl/sbh_round.sv
// ============================================================================
// SHA-256 round unit
// Working variables, one shared round per cycle, and the chaining words.
// ============================================================================
`default_nettype none

module sbh_round (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sbh_pkg::ctrl_t ctrl,
    input  wire logic [31:0]    w0,
    output logic [31:0]         digest_word
);

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + sbh_pkg::bsig1(v_reg[4]) + ch
               + sbh_pkg::ROUND_K[ctrl.round_idx] + w0;
    assign t2  = sbh_pkg::bsig0(v_reg[0]) + maj;

    always_comb
    begin
        v_next = v_reg;
        if (ctrl.round_load)
        begin
            v_next = chain_reg;
        end
        else if (ctrl.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // While the digest is read out the words move toward word 0, and the
    // initial values fill in from the top, so the last beat leaves them reset.
    always_comb
    begin
        chain_next = chain_reg;
        if (ctrl.final_add)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end
        else if (ctrl.out_shift)
        begin
            for (int i = 0; i < 7; i++)
            begin
                chain_next[i] = chain_reg[i+1];
            end
            chain_next[7] = sbh_pkg::INIT_H[ctrl.out_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= sbh_pkg::INIT_H;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign digest_word = chain_reg[0];

endmodule

`default_nettype wire
